[rtl/core/rpfc_pkg.sv]
// ----------------------------------------------------------------------------
// rpfc_pkg
// Shared types, register codes and constants of the RGB24 pixel format
// converter: pixel and queue entry layouts, output format codes, BT.601 terms.
// ----------------------------------------------------------------------------
package rpfc_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);

  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [DIM_W-1:0] RST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_HEIGHT = DIM_W'(480);

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    MODE_RGB32 = 4'd0,
    MODE_RGB16 = 4'd1,
    MODE_RGB15 = 4'd2,
    MODE_BGR32 = 4'd3,
    MODE_BGR24 = 4'd4,
    MODE_BGR16 = 4'd5,
    MODE_BGR15 = 4'd6,
    MODE_UYVY  = 4'd7,
    MODE_YUY2  = 4'd8,
    MODE_NV12  = 4'd9,
    MODE_NV21  = 4'd10
  } mode_t;

  typedef enum logic [3:0] {
    OP_RGB32,
    OP_RGB16,
    OP_RGB15,
    OP_BGR32,
    OP_BGR24,
    OP_BGR16,
    OP_BGR15,
    OP_UYVY,
    OP_YUY2,
    OP_NV_Y,
    OP_NV12_YC,
    OP_NV21_YC
  } op_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  typedef struct packed {
    op_t    op;
    pixel_t pix;
    pixel_t held;
  } entry_t;

  localparam logic [2:0] BYTES_1 = 3'd1;
  localparam logic [2:0] BYTES_2 = 3'd2;
  localparam logic [2:0] BYTES_3 = 3'd3;
  localparam logic [2:0] BYTES_4 = 3'd4;

  localparam logic PLANE_MAIN   = 1'b0;
  localparam logic PLANE_CHROMA = 1'b1;

  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam logic [15:0] K_Y_R = 16'd66;
  localparam logic [15:0] K_Y_G = 16'd129;
  localparam logic [15:0] K_Y_B = 16'd25;
  localparam logic [15:0] K_U_R = 16'd38;
  localparam logic [15:0] K_U_G = 16'd74;
  localparam logic [15:0] K_C_P = 16'd112;
  localparam logic [15:0] K_V_G = 16'd94;
  localparam logic [15:0] K_V_B = 16'd18;

  localparam logic [15:0] Y_ROUND  = 16'd128;
  localparam logic [7:0]  Y_OFFSET = 8'd16;
  localparam logic [15:0] C_BIAS   = 16'd32896;

endpackage

[rtl/core/rgb24_pixel_format_converter_core.sv]
// ----------------------------------------------------------------------------
// rgb24_pixel_format_converter_core
// Packs raster-order 8-bit RGB pixels into RGB/BGR 32/24/16/15-bit words,
// UYVY/YUY2 pixel pairs, or NV12/NV21 luma and chroma planes (BT.601).
//
//   channel  handshake               payload
//   in       in_valid / in_stall     in_red, in_green, in_blue
//   out      out_valid / out_stall   out_data, out_byte_count, out_plane,
//                                    out_last_of_run
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per cycle is accepted while in_stall is low; it passes the queue,
// product and output registers. Even-row, even-column NV12/NV21 pixels below
// the even-rounded size give two results; a four-entry queue absorbs them.
// Synchronous active-low reset; no clearing pass, cfg_ready is always high.
// out_stall holds the output register; when the queue fills, in_stall rises.
// ----------------------------------------------------------------------------
module rgb24_pixel_format_converter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_red,
  input  logic [7:0]                        in_green,
  input  logic [7:0]                        in_blue,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_data,
  output logic [2:0]                        out_byte_count,
  output logic                              out_plane,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rpfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rpfc_pkg::*;

  pixel_t  in_pix;
  entry_t  push_entry;
  entry_t  head;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;

  assign cfg_ready = 1'b1;
  assign in_pix    = '{r: in_red, g: in_green, b: in_blue};

  rpfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (in_pix),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  rpfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (head)
  );

  rpfc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .out_byte_count  (out_byte_count),
    .out_plane       (out_plane),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[rtl/core/rpfc_front.sv]
// ----------------------------------------------------------------------------
// rpfc_front
// Input side: configuration registers, frame position, pixel pairing and
// classification of each pixel into a queue entry for the back end.
// ----------------------------------------------------------------------------
module rpfc_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rpfc_pkg::pixel_t                    in_pix,
  input  logic                                cfg_valid,
  input  logic [rpfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output rpfc_pkg::entry_t                    q_entry
);
  import rpfc_pkg::*;

  mode_t               mode_r;
  logic [DIM_W-1:0]    width_r;
  logic [DIM_W-1:0]    height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                phase_r, phase_nxt;
  pixel_t              held_r;

  logic [COL_W:0]      w_eff;
  logic [ROW_W:0]      h_eff;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic                accept;
  logic                chroma_here;
  logic                pair_mode;
  logic                line_end;
  logic                frame_end;
  logic                cfg_restart;

  always_comb begin
    if (width_r == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(width_r);
    end
    if (height_r == '0) begin
      h_eff = (ROW_W+1)'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (ROW_W+1)'(height_r);
    end
  end

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign col_inc   = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc   = {1'b0, row_r} + (ROW_W+1)'(1);
  assign line_end  = col_inc >= w_eff;
  assign frame_end = line_end && (row_inc >= h_eff);
  assign pair_mode = (mode_r == MODE_UYVY) || (mode_r == MODE_YUY2);

  assign cfg_restart = cfg_valid && (cfg_index inside {REG_MODE, REG_WIDTH, REG_HEIGHT});

  assign chroma_here = !col_r[0] && !row_r[0]
                       && ({1'b0, col_r} < {w_eff[COL_W:1], 1'b0})
                       && ({1'b0, row_r} < {h_eff[ROW_W:1], 1'b0});

  always_comb begin
    q_entry.pix  = in_pix;
    q_entry.held = held_r;
    q_entry.op   = OP_RGB32;
    q_push       = accept;
    case (mode_r)
      MODE_RGB32: q_entry.op = OP_RGB32;
      MODE_RGB16: q_entry.op = OP_RGB16;
      MODE_RGB15: q_entry.op = OP_RGB15;
      MODE_BGR32: q_entry.op = OP_BGR32;
      MODE_BGR24: q_entry.op = OP_BGR24;
      MODE_BGR16: q_entry.op = OP_BGR16;
      MODE_BGR15: q_entry.op = OP_BGR15;
      MODE_UYVY: begin
        q_entry.op = OP_UYVY;
        q_push     = accept && phase_r;
      end
      MODE_YUY2: begin
        q_entry.op = OP_YUY2;
        q_push     = accept && phase_r;
      end
      MODE_NV12: q_entry.op = chroma_here ? OP_NV12_YC : OP_NV_Y;
      MODE_NV21: q_entry.op = chroma_here ? OP_NV21_YC : OP_NV_Y;
      default:   q_push     = 1'b0;
    endcase
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    phase_nxt = phase_r;
    if (cfg_restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      phase_nxt = 1'b0;
    end else if (accept) begin
      if (pair_mode) begin
        phase_nxt = !phase_r;
      end
      if (line_end) begin
        col_nxt = '0;
        if (frame_end) begin
          row_nxt   = '0;
          phase_nxt = 1'b0;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RGB32;
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
      phase_r  <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      phase_r <= phase_nxt;
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:   mode_r   <= mode_t'(cfg_data[3:0]);
          REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
          REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pair_mode && !phase_r) begin
      held_r <= in_pix;
    end
  end

endmodule

[rtl/core/rpfc_queue.sv]
// ----------------------------------------------------------------------------
// rpfc_queue
// Short FIFO of classified pixel entries between the front and back ends.
// ----------------------------------------------------------------------------
module rpfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rpfc_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output rpfc_pkg::entry_t  head
);
  import rpfc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  entry_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = count_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue push while full");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> count_r == $past(count_r) - (PTR_W+1)'(1))
    else $error("queue pop lost");

endmodule

[rtl/core/rpfc_back.sv]
// ----------------------------------------------------------------------------
// rpfc_back
// Output side: BT.601 products, luma/chroma sums, byte packing and the
// output register, with a second chroma beat for planar chroma pixels.
// ----------------------------------------------------------------------------
module rpfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  rpfc_pkg::entry_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_data,
  output logic [2:0]        out_byte_count,
  output logic              out_plane,
  output logic              out_last_of_run
);
  import rpfc_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  op_t          s1_op_r;
  pixel_t       s1_pix_r;
  logic [15:0]  pa_yr_r, pa_yg_r, pa_yb_r;
  logic [15:0]  pa_ur_r, pa_ug_r, pa_cb_r;
  logic [15:0]  pa_cr_r, pa_vg_r, pa_vb_r;
  logic [15:0]  pb_yr_r, pb_yg_r, pb_yb_r;

  logic         out_valid_r, out_valid_nxt;
  logic         pend_r, pend_nxt;
  logic [31:0]  out_data_r;
  logic [2:0]   out_count_r;
  logic         out_plane_r;
  logic         out_last_r;
  logic [15:0]  chroma_r;

  pixel_t       pa;
  pixel_t       pb;
  logic         s1_ready;
  logic         s2_free;
  logic         out_take;
  logic         load;

  logic [15:0]  ya_sum, ua_sum, va_sum, yb_sum;
  logic [7:0]   ya, ua, va, yb;
  logic [31:0]  ld_data;
  logic [2:0]   ld_count;
  logic         ld_last;
  logic         ld_pend;
  logic [15:0]  ld_chroma;

  assign out_take     = out_valid_r && !out_stall;
  assign s2_free      = !out_valid_r || (out_take && !pend_r);
  assign load         = s1_valid_r && s2_free;
  assign s1_ready     = !s1_valid_r || s2_free;
  assign q_pop        = !q_empty && s1_ready;
  assign s1_valid_nxt = s1_ready ? q_pop : s1_valid_r;

  assign pa = ((q_head.op == OP_UYVY) || (q_head.op == OP_YUY2)) ? q_head.held : q_head.pix;
  assign pb = q_head.pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op_r  <= q_head.op;
      s1_pix_r <= q_head.pix;
      pa_yr_r  <= 16'(pa.r) * K_Y_R;
      pa_yg_r  <= 16'(pa.g) * K_Y_G;
      pa_yb_r  <= 16'(pa.b) * K_Y_B;
      pa_ur_r  <= 16'(pa.r) * K_U_R;
      pa_ug_r  <= 16'(pa.g) * K_U_G;
      pa_cb_r  <= 16'(pa.b) * K_C_P;
      pa_cr_r  <= 16'(pa.r) * K_C_P;
      pa_vg_r  <= 16'(pa.g) * K_V_G;
      pa_vb_r  <= 16'(pa.b) * K_V_B;
      pb_yr_r  <= 16'(pb.r) * K_Y_R;
      pb_yg_r  <= 16'(pb.g) * K_Y_G;
      pb_yb_r  <= 16'(pb.b) * K_Y_B;
    end
  end

  always_comb begin
    ya_sum = pa_yr_r + pa_yg_r + pa_yb_r + Y_ROUND;
    yb_sum = pb_yr_r + pb_yg_r + pb_yb_r + Y_ROUND;
    ua_sum = pa_cb_r + C_BIAS - pa_ur_r - pa_ug_r;
    va_sum = pa_cr_r + C_BIAS - pa_vg_r - pa_vb_r;
    ya     = ya_sum[15:8] + Y_OFFSET;
    yb     = yb_sum[15:8] + Y_OFFSET;
    ua     = ua_sum[15:8];
    va     = va_sum[15:8];
  end

  always_comb begin
    ld_data   = '0;
    ld_count  = BYTES_4;
    ld_last   = 1'b1;
    ld_pend   = 1'b0;
    ld_chroma = {va, ua};
    case (s1_op_r)
      OP_RGB32: ld_data = {s1_pix_r.r, s1_pix_r.g, s1_pix_r.b, FILL_BYTE};
      OP_RGB16: begin
        ld_data  = {16'd0, s1_pix_r.r[7:3], s1_pix_r.g[7:2], s1_pix_r.b[7:3]};
        ld_count = BYTES_2;
      end
      OP_RGB15: begin
        ld_data  = {16'd0, 1'b1, s1_pix_r.r[7:3], s1_pix_r.g[7:3], s1_pix_r.b[7:3]};
        ld_count = BYTES_2;
      end
      OP_BGR32: ld_data = {s1_pix_r.b, s1_pix_r.g, s1_pix_r.r, FILL_BYTE};
      OP_BGR24: begin
        ld_data  = {8'd0, s1_pix_r.b, s1_pix_r.g, s1_pix_r.r};
        ld_count = BYTES_3;
      end
      OP_BGR16: begin
        ld_data  = {16'd0, s1_pix_r.b[7:3], s1_pix_r.g[7:2], s1_pix_r.r[7:3]};
        ld_count = BYTES_2;
      end
      OP_BGR15: begin
        ld_data  = {16'd0, 1'b1, s1_pix_r.b[7:3], s1_pix_r.g[7:3], s1_pix_r.r[7:3]};
        ld_count = BYTES_2;
      end
      OP_UYVY: ld_data = {yb, ua, ya, va};
      OP_YUY2: ld_data = {ua, yb, va, ya};
      OP_NV_Y: begin
        ld_data  = {24'd0, ya};
        ld_count = BYTES_1;
      end
      OP_NV12_YC: begin
        ld_data  = {24'd0, ya};
        ld_count = BYTES_1;
        ld_last  = 1'b0;
        ld_pend  = 1'b1;
      end
      OP_NV21_YC: begin
        ld_data   = {24'd0, ya};
        ld_count  = BYTES_1;
        ld_last   = 1'b0;
        ld_pend   = 1'b1;
        ld_chroma = {ua, va};
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      pend_nxt      = ld_pend;
    end else if (out_take) begin
      out_valid_nxt = pend_r;
      pend_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r  <= ld_data;
      out_count_r <= ld_count;
      out_plane_r <= PLANE_MAIN;
      out_last_r  <= ld_last;
      chroma_r    <= ld_chroma;
    end else if (out_take && pend_r) begin
      out_data_r  <= {16'd0, chroma_r};
      out_count_r <= BYTES_2;
      out_plane_r <= PLANE_CHROMA;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_byte_count  = out_count_r;
  assign out_plane       = out_plane_r;
  assign out_last_of_run = out_last_r;

  a_pend_on_luma: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r && !out_last_r && (out_plane_r == PLANE_MAIN))
    else $error("chroma pending without a luma result shown");

  a_chroma_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && pend_r) |=> out_valid_r && (out_plane_r == PLANE_CHROMA)
                             && out_last_r && (out_count_r == BYTES_2))
    else $error("chroma result did not follow luma");

  a_chroma_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_plane_r == PLANE_CHROMA)) |-> out_last_r && !pend_r)
    else $error("chroma result not final");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB24 pixel format converter core. A table of
// known pixels walks every output format first; then random register settings
// (odd, tiny, zero and oversize frames) carry random pixels through the block.
// Every result transfer is compared field by field with a local model of the
// packing, BT.601 and frame-position logic, under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import rpfc_pkg::*;

  localparam int          HALF_PERIOD   = 2;
  localparam int          RESET_CYCLES  = 10;
  localparam int          DRAIN_CYCLES  = 16;
  localparam int          CHOKE_CYCLES  = 80;
  localparam int          RANDOM_PIXELS = 1150;
  localparam int          TIMEOUT_NS    = 3_000_000;
  localparam int          REPORT_LIMIT  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [3:0]  MODE_SPARE_LO = 4'd11;
  localparam logic [3:0]  MODE_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        plane;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [3:0]  mode;
    pixel_t      pix;
    logic        typed;
    logic [31:0] want;
  } pixel_row_t;

  localparam int DIR_ROWS = 25;
  localparam pixel_row_t PIXEL_TABLE [DIR_ROWS] = '{
    '{MODE_RGB32, 24'hFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{MODE_RGB32, 24'h000000, 1'b1, 32'h000000FF},
    '{MODE_RGB32, 24'h123456, 1'b1, 32'h123456FF},
    '{MODE_RGB16, 24'hFFFFFF, 1'b1, 32'h0000FFFF},
    '{MODE_RGB16, 24'hFF0000, 1'b1, 32'h0000F800},
    '{MODE_RGB15, 24'h000000, 1'b1, 32'h00008000},
    '{MODE_RGB15, 24'h00FF00, 1'b1, 32'h000083E0},
    '{MODE_BGR32, 24'h123456, 1'b1, 32'h563412FF},
    '{MODE_BGR24, 24'h123456, 1'b1, 32'h00563412},
    '{MODE_BGR24, 24'hFFFFFF, 1'b1, 32'h00FFFFFF},
    '{MODE_BGR16, 24'hFF0000, 1'b1, 32'h0000001F},
    '{MODE_BGR16, 24'h0000FF, 1'b1, 32'h0000F800},
    '{MODE_BGR15, 24'hFF0000, 1'b1, 32'h0000801F},
    '{MODE_BGR15, 24'h00FF00, 1'b1, 32'h000083E0},
    '{MODE_UYVY,  24'h000000, 1'b0, 32'h0},
    '{MODE_UYVY,  24'h000000, 1'b1, 32'h10801080},
    '{MODE_YUY2,  24'h000000, 1'b0, 32'h0},
    '{MODE_YUY2,  24'hFFFFFF, 1'b1, 32'h80EB8010},
    '{MODE_UYVY,  24'hFF0000, 1'b0, 32'h0},
    '{MODE_UYVY,  24'h0000FF, 1'b0, 32'h0},
    '{MODE_NV12,  24'h000000, 1'b1, 32'h00000010},
    '{MODE_NV12,  24'hFFFFFF, 1'b0, 32'h0},
    '{MODE_NV21,  24'h0000FF, 1'b0, 32'h0},
    '{MODE_SPARE_HI, 24'hFFFFFF, 1'b0, 32'h0},
    '{MODE_SPARE_LO, 24'h000000, 1'b0, 32'h0}
  };

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_red          = '0;
  logic [7:0]            in_green        = '0;
  logic [7:0]            in_blue         = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [31:0]           out_data;
  logic [2:0]            out_byte_count;
  logic                  out_plane;
  logic                  out_last_of_run;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  // local copy of the converter state
  logic [3:0]       cur_mode   = MODE_RGB32;
  logic [DIM_W-1:0] cur_width  = RST_WIDTH;
  logic [DIM_W-1:0] cur_height = RST_HEIGHT;
  pixel_t           held_pix   = '0;
  int               col_pos    = 0;
  int               row_pos    = 0;
  bit               odd_pending = 1'b0;

  word_t pending_words [$];
  int    fail_count     = 0;
  int    results_seen   = 0;
  int    pixels_sent    = 0;
  int    settings_count = 0;
  int    mode_pixels [16];
  int    in_calm        = 0;
  int    choke_asked    = 0;
  int    choke_taken    = 0;
  int    choke_left     = 0;
  int    stall_left     = 0;
  int    calm_left      = 0;

  rgb24_pixel_format_converter_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .out_byte_count  (out_byte_count),
    .out_plane       (out_plane),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d results still outstanding", pending_words.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic [7:0] luma_of(pixel_t p);
    int r, g, b;
    r = p.r;
    g = p.g;
    b = p.b;
    return 8'(((66 * r + 129 * g + 25 * b + 128) >> 8) + 16);
  endfunction

  function automatic logic [7:0] cb_of(pixel_t p);
    int r, g, b;
    r = p.r;
    g = p.g;
    b = p.b;
    return 8'((-38 * r - 74 * g + 112 * b + 32896) >> 8);
  endfunction

  function automatic logic [7:0] cr_of(pixel_t p);
    int r, g, b;
    r = p.r;
    g = p.g;
    b = p.b;
    return 8'((112 * r - 94 * g - 18 * b + 32896) >> 8);
  endfunction

  function automatic word_t mk_word(logic [31:0] data, logic [2:0] nbytes,
                                    logic plane, logic last);
    word_t w;
    w = '{data: data, nbytes: nbytes, plane: plane, last: last};
    return w;
  endfunction

  // expected words for one pixel; advances the frame position
  function automatic int pack_pixel(pixel_t p, output word_t res [2]);
    int  n, w, h;
    bit  chroma;
    logic [7:0] y0, y1, cb, cr;
    n = 0;
    w = eff_dim(cur_width, MAX_WIDTH);
    h = eff_dim(cur_height, MAX_HEIGHT);
    res[0] = '0;
    res[1] = '0;
    case (cur_mode)
      MODE_RGB32: begin
        res[0] = mk_word({p.r, p.g, p.b, FILL_BYTE}, BYTES_4, PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_RGB16: begin
        res[0] = mk_word({16'h0, p.r[7:3], p.g[7:2], p.b[7:3]}, BYTES_2, PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_RGB15: begin
        res[0] = mk_word({16'h0, 1'b1, p.r[7:3], p.g[7:3], p.b[7:3]}, BYTES_2,
                         PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_BGR32: begin
        res[0] = mk_word({p.b, p.g, p.r, FILL_BYTE}, BYTES_4, PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_BGR24: begin
        res[0] = mk_word({8'h0, p.b, p.g, p.r}, BYTES_3, PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_BGR16: begin
        res[0] = mk_word({16'h0, p.b[7:3], p.g[7:2], p.r[7:3]}, BYTES_2, PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_BGR15: begin
        res[0] = mk_word({16'h0, 1'b1, p.b[7:3], p.g[7:3], p.r[7:3]}, BYTES_2,
                         PLANE_MAIN, 1'b1);
        n = 1;
      end
      MODE_UYVY, MODE_YUY2: begin
        if (!odd_pending) begin
          held_pix = p;
          odd_pending = 1'b1;
        end else begin
          y0 = luma_of(held_pix);
          cb = cb_of(held_pix);
          cr = cr_of(held_pix);
          y1 = luma_of(p);
          if (cur_mode == MODE_UYVY) begin
            res[0] = mk_word({y1, cb, y0, cr}, BYTES_4, PLANE_MAIN, 1'b1);
          end else begin
            res[0] = mk_word({cb, y1, cr, y0}, BYTES_4, PLANE_MAIN, 1'b1);
          end
          n = 1;
          odd_pending = 1'b0;
        end
      end
      MODE_NV12, MODE_NV21: begin
        chroma = (col_pos % 2 == 0) && (row_pos % 2 == 0) &&
                 (col_pos < (w & ~1)) && (row_pos < (h & ~1));
        res[0] = mk_word({24'h0, luma_of(p)}, BYTES_1, PLANE_MAIN, !chroma);
        n = 1;
        if (chroma) begin
          cb = cb_of(p);
          cr = cr_of(p);
          if (cur_mode == MODE_NV12) begin
            res[1] = mk_word({16'h0, cr, cb}, BYTES_2, PLANE_CHROMA, 1'b1);
          end else begin
            res[1] = mk_word({16'h0, cb, cr}, BYTES_2, PLANE_CHROMA, 1'b1);
          end
          n = 2;
        end
      end
      default: begin
      end
    endcase
    col_pos = col_pos + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        odd_pending = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 2);
    if (roll < 97) return $urandom_range(3, 8);
    return $urandom_range(16, 40);
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return DIM_W'(MAX_WIDTH);
      2: return DIM_W'($urandom_range(MAX_WIDTH + 1, 8191));
      3: return DIM_W'($urandom);
      default: return DIM_W'($urandom_range(1, 7));
    endcase
  endfunction

  task automatic report_fail(string what);
    fail_count = fail_count + 1;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:   cur_mode   = value[3:0];
      REG_WIDTH:  cur_width  = value;
      REG_HEIGHT: cur_height = value;
      default:    return;
    endcase
    col_pos = 0;
    row_pos = 0;
    odd_pending = 1'b0;
  endtask

  // hold valid high across back-to-back transfers; drop it only for a gap
  task automatic push_pixel(pixel_t p, logic typed, logic [31:0] typed_data);
    word_t res [2];
    int    n;
    in_valid <= 1'b1;
    in_red   <= p.r;
    in_green <= p.g;
    in_blue  <= p.b;
    do @(posedge clk); while (in_stall);
    mode_pixels[cur_mode] = mode_pixels[cur_mode] + 1;
    pixels_sent = pixels_sent + 1;
    n = pack_pixel(p, res);
    if (typed && n > 0) res[0].data = typed_data;
    for (int k = 0; k < n; k++) pending_words.push_back(res[k]);
  endtask

  task automatic sender_idle();
    int gap;
    if (in_calm != 0) begin
      in_calm = in_calm - 1;
      return;
    end
    case ($urandom_range(0, 99)) inside
      [0:2]: in_calm = $urandom_range(40, 200);
      [3:29]: begin
        gap = idle_len();
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      default: begin
      end
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (choke_left != 0) begin
      out_stall  <= 1'b1;
      choke_left <= choke_left - 1;
    end else if (choke_taken != choke_asked) begin
      out_stall   <= 1'b1;
      choke_left  <= CHOKE_CYCLES;
      choke_taken <= choke_taken + 1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 99)) inside
        [0:2]:  calm_left  <= $urandom_range(40, 200);
        [3:24]: stall_left <= idle_len();
        default: begin
        end
      endcase
    end
  end

  always @(posedge clk) begin
    word_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = mk_word(out_data, out_byte_count, out_plane, out_last_of_run);
      results_seen = results_seen + 1;
      if (pending_words.size() == 0) begin
        report_fail($sformatf("unexpected result data=%h bytes=%0d plane=%0d last=%0d",
                              got.data, got.nbytes, got.plane, got.last));
      end else begin
        want = pending_words.pop_front();
        if (got.data !== want.data || got.nbytes !== want.nbytes ||
            got.plane !== want.plane || got.last !== want.last) begin
          report_fail($sformatf({"mismatch: want data=%h bytes=%0d plane=%0d last=%0d,",
                                 " got data=%h bytes=%0d plane=%0d last=%0d"},
                                want.data, want.nbytes, want.plane, want.last,
                                got.data, got.nbytes, got.plane, got.last));
        end
      end
    end
  end

  initial begin
    int    n_pix, random_pixels, phase;
    bit    choking;
    string tally;
    logic [3:0] mode_pick;
    pixel_t     pix;
    random_pixels = 0;
    phase = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PIXEL_TABLE[i]) begin
      if (PIXEL_TABLE[i].mode != cur_mode) begin
        settle();
        cfg_write(REG_MODE, CFG_DATA_W'(PIXEL_TABLE[i].mode));
        cfg_valid <= 1'b0;
        settings_count = settings_count + 1;
      end
      push_pixel(PIXEL_TABLE[i].pix, PIXEL_TABLE[i].typed, PIXEL_TABLE[i].want);
      sender_idle();
    end

    while (random_pixels < RANDOM_PIXELS) begin
      settle();
      if (phase % 6 == 5) begin
        // no restart: the frame carries on from the last phase
        cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
      end else begin
        if (phase < 16) begin
          mode_pick = phase[3:0];
        end else begin
          case ($urandom_range(0, 9))
            0:       mode_pick = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            1, 2, 3, 4: mode_pick = 4'($urandom_range(MODE_UYVY, MODE_NV21));
            default: mode_pick = 4'($urandom_range(MODE_RGB32, MODE_BGR15));
          endcase
        end
        cfg_write(REG_MODE, {9'($urandom), mode_pick});
        cfg_write(REG_WIDTH, pick_dim());
        cfg_write(REG_HEIGHT, pick_dim());
      end
      cfg_valid <= 1'b0;
      settings_count = settings_count + 1;

      choking = (phase == 7) || (phase == 9) || (phase == 10);
      n_pix = choking ? 60 : ($urandom_range(0, 7) == 0 ? 150 : $urandom_range(20, 60));
      for (int k = 0; k < n_pix; k++) begin
        if (choking && k == 3) choke_asked = choke_asked + 1;
        if (phase % 4 == 2 && k == n_pix / 2) settle();
        pix = '{pick_level(), pick_level(), pick_level()};
        push_pixel(pix, 1'b0, 32'h0);
        random_pixels = random_pixels + 1;
        if (!(choking && k < 45)) sender_idle();
      end
      phase = phase + 1;
    end

    settle();
    tally = "";
    foreach (mode_pixels[m]) tally = {tally, $sformatf(" %0d", mode_pixels[m])};
    $display("summary: %0d pixel transfers under %0d register settings, %0d results compared",
             pixels_sent, settings_count, results_seen);
    $display("pixels per format code 0..15:%s", tally);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
